// ----- hw/rtl/gpio_ports_with_ping_echo_unit_assert.svh -----
// Assertion macros shared by the GPIO block with ping echo.
// Included by the modules that check their own logic; needs nothing else.
`ifndef GPIO_PORTS_WITH_PING_ECHO_UNIT_ASSERT_SVH
`define GPIO_PORTS_WITH_PING_ECHO_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gpe_pkg.sv -----
// Shared constants, opcodes and types for the GPIO block with ping echo.
// No dependencies; used by the interfaces, the echo unit and the top level.
package gpe_pkg;

  // block geometry
  localparam int PORT_COUNT      = 5;
  localparam int PORT_BITS       = 16;
  localparam int PING_PORT_INDEX = 0;
  localparam int ECHO_BIT        = 0;
  localparam int TRIGGER_BIT     = 1;
  localparam int TIME_BITS       = 32;

  // field widths, fixed by the item format
  localparam int OP_W    = 4;
  localparam int PORT_W  = 3;
  localparam int DATA_W  = 16;
  localparam int CFG_W   = 32;
  localparam int PADDR_W = 3;

  // port index width, at least one bit
  localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  // valid bits of a port
  localparam logic [DATA_W-1:0] PMASK = DATA_W'((32'h1 << PORT_BITS) - 1);

  // echo width: round(d * 148 / 16000), d in sixteenths of an inch
  localparam int          PROD_W      = 24;
  localparam int          DIST_SCALE  = 148;
  localparam int          DIST_ROUND  = 8000;
  localparam int          DIV_SHIFT   = 7;   // 16000 = 128 * 125
  localparam int          QUOT_IN_W   = PROD_W - DIV_SHIFT;
  localparam int          RECIP_W     = 18;
  localparam int          RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_125 = 18'd134218;  // ceil(2^24 / 125)
  localparam int          WIDTH_W     = 10;

  // configuration register index (address bit 2)
  localparam logic CFG_IDX_DIST = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_SETDIR   = 4'd0,
    OP_MKINPUT  = 4'd1,
    OP_MKOUTPUT = 4'd2,
    OP_READ     = 4'd3,
    OP_WRITE    = 4'd4,
    OP_SETBITS  = 4'd5,
    OP_CLRBITS  = 4'd6,
    OP_TOGGLE   = 4'd7,
    OP_DRIVE    = 4'd8,
    OP_GETLATCH = 4'd9,
    OP_TICK     = 4'd10
  } gpe_op_t;

  // strobes from the port logic to the echo unit
  typedef struct packed {
    logic tick;     // advance the millisecond counter
    logic arm;      // trigger rose: store the time and arm
    logic cfg_we;   // write the distance register
  } echo_ctrl_t;

endpackage

// ----- hw/rtl/gpe_ifs.sv -----
// Valid/ready channel interfaces for the GPIO block: request items in,
// result items out. Depends on gpe_pkg for the field widths.
interface gpe_in_if;
  import gpe_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [PORT_W-1:0] port;
  logic [DATA_W-1:0] pattern;
  logic [DATA_W-1:0] drive_mask;

  modport source (output valid, opcode, port, pattern, drive_mask, input ready);
  modport sink   (input valid, opcode, port, pattern, drive_mask, output ready);
endinterface

interface gpe_out_if;
  import gpe_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              error;

  modport source (output valid, read_data, error, input ready);
  modport sink   (input valid, read_data, error, output ready);
endinterface

// ----- hw/rtl/gpio_ports_with_ping_echo_unit.sv -----
// Top level of the multi-port GPIO block with simulated ping sensor.
// Depends on gpe_pkg, gpe_ifs, gpe_echo and the assertion header.
//
//   channel   direction  handshake           payload
//   in_bus    in         valid/ready         opcode, port, pattern, drive_mask
//   out_bus   out        valid/ready         read_data, error
//   cfg_*     in         APB write/read      ping_distance_sixteenths at 0x0
//
// One item per cycle while out_bus is ready: an item is registered on entry,
// then decoded and applied, and its result lands in the output register.
// A stalled result holds the output register and the entry register; in_bus
// stays ready while the entry register is empty or moving on.
// Synchronous active-low reset clears all port registers, the millisecond
// counter, the arm flag and the distance register.
`include "gpio_ports_with_ping_echo_unit_assert.svh"

module gpio_ports_with_ping_echo_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  gpe_in_if.sink                        in_bus,
  gpe_out_if.source                     out_bus,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gpe_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [gpe_pkg::CFG_W-1:0]     cfg_pwdata,
  output logic [gpe_pkg::CFG_W-1:0]     cfg_prdata,
  output logic                          cfg_pready
);
  import gpe_pkg::*;

  // entry register
  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [PORT_W-1:0] s1_port_r;
  logic [DATA_W-1:0] s1_pat_r;
  logic [DATA_W-1:0] s1_mask_r;

  // result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_err_r;
  logic [DATA_W-1:0] data_nxt;
  logic              err_nxt;

  // port state
  logic [DATA_W-1:0] dir_r [PORT_COUNT];
  logic [DATA_W-1:0] lat_r [PORT_COUNT];
  logic [DATA_W-1:0] pin_r [PORT_COUNT];

  logic              adv;
  logic              step;
  logic              port_ok;
  logic              is_ping;
  logic [IDX_W-1:0]  p_idx;
  logic [DATA_W-1:0] dir_sel, lat_sel, pin_sel, pins;
  logic [DATA_W-1:0] dir_nxt, lat_nxt, pin_nxt;
  logic              dir_we, lat_we, pin_we, lat_store;
  logic              echo;
  logic [DATA_W-1:0] dist_val;
  echo_ctrl_t        ectrl;

  // pipeline flow
  assign adv          = !out_valid_r || out_bus.ready;
  assign step         = s1_valid_r && adv;
  assign in_bus.ready = !s1_valid_r || adv;

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
    if (in_bus.valid && in_bus.ready) begin
      s1_op_r   <= in_bus.opcode;
      s1_port_r <= in_bus.port;
      s1_pat_r  <= in_bus.pattern;
      s1_mask_r <= in_bus.drive_mask;
    end
  end

  // select the addressed port
  assign port_ok = {1'b0, s1_port_r} < (PORT_W+1)'(PORT_COUNT);
  assign p_idx   = s1_port_r[IDX_W-1:0];
  assign is_ping = s1_port_r == PORT_W'(PING_PORT_INDEX);
  assign dir_sel = dir_r[p_idx];
  assign lat_sel = lat_r[p_idx];
  assign pin_sel = pin_r[p_idx];

  // decode the operation
  always_comb begin
    dir_nxt   = dir_sel;
    lat_nxt   = lat_sel;
    pin_nxt   = pin_sel;
    dir_we    = 1'b0;
    lat_we    = 1'b0;
    lat_store = 1'b0;
    pin_we    = 1'b0;
    data_nxt  = '0;
    err_nxt   = 1'b0;
    pins      = pin_sel;
    if (is_ping) begin
      pins[ECHO_BIT] = echo;
    end
    unique case (gpe_op_t'(s1_op_r))
      OP_SETDIR: begin
        dir_nxt = s1_pat_r & PMASK;
        dir_we  = 1'b1;
      end
      OP_MKINPUT: begin
        dir_nxt = (dir_sel | s1_pat_r) & PMASK;
        dir_we  = 1'b1;
      end
      OP_MKOUTPUT: begin
        dir_nxt = dir_sel & ~s1_pat_r;
        dir_we  = 1'b1;
      end
      OP_READ: begin
        data_nxt = ((lat_sel & ~dir_sel) | (pins & dir_sel)) & PMASK;
      end
      OP_WRITE: begin
        lat_nxt   = s1_pat_r & PMASK;
        lat_we    = 1'b1;
        lat_store = 1'b1;
      end
      OP_SETBITS: begin
        lat_nxt   = (lat_sel | s1_pat_r) & PMASK;
        lat_we    = 1'b1;
        lat_store = 1'b1;
      end
      OP_CLRBITS: begin
        lat_nxt = lat_sel & ~s1_pat_r;
        lat_we  = 1'b1;
      end
      OP_TOGGLE: begin
        lat_nxt   = (lat_sel ^ s1_pat_r) & PMASK;
        lat_we    = 1'b1;
        lat_store = 1'b1;
      end
      OP_DRIVE: begin
        pin_nxt = ((pin_sel & ~s1_mask_r) | (s1_pat_r & s1_mask_r)) & PMASK;
        pin_we  = 1'b1;
      end
      OP_GETLATCH: begin
        data_nxt = lat_sel;
      end
      OP_TICK: begin
      end
      default: begin
      end
    endcase
    // invalid port: drop every update and flag it, except on tick and undefined opcodes
    if (!port_ok && (s1_op_r != OP_TICK) && (s1_op_r <= OP_GETLATCH)) begin
      err_nxt  = 1'b1;
      data_nxt = '0;
    end
  end

  // strobes to the echo unit
  assign ectrl.tick   = step && (s1_op_r == OP_TICK);
  assign ectrl.arm    = step && port_ok && is_ping && lat_store
                     && !lat_sel[TRIGGER_BIT] && lat_nxt[TRIGGER_BIT];
  assign ectrl.cfg_we = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                     && (cfg_paddr[2] == CFG_IDX_DIST);

  // update the addressed port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        dir_r[i] <= '0;
        lat_r[i] <= '0;
        pin_r[i] <= '0;
      end
    end else if (step && port_ok) begin
      if (dir_we) begin
        dir_r[p_idx] <= dir_nxt;
      end
      if (lat_we) begin
        lat_r[p_idx] <= lat_nxt;
      end
      if (pin_we) begin
        pin_r[p_idx] <= pin_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (step) begin
      out_data_r <= data_nxt;
      out_err_r  <= err_nxt;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.read_data = out_data_r;
  assign out_bus.error     = out_err_r;

  gpe_echo u_echo (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ectrl),
    .cfg_dist (cfg_pwdata[DATA_W-1:0]),
    .dist_val (dist_val),
    .echo     (echo)
  );

  // configuration read-back
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_DIST) ? CFG_W'(dist_val) : '0;

  `GPE_ASSERT_NEXT(a_step_gives_result, clk, rst_n, step,
                   out_valid_r, "applied item left no result")
  `GPE_ASSERT_NOW(a_error_reads_zero, clk, rst_n, out_valid_r && out_err_r,
                  out_data_r == '0, "error result carries data")
  `GPE_ASSERT_NOW(a_stall_means_full, clk, rst_n, !in_bus.ready,
                  s1_valid_r && out_valid_r, "input held off with room to spare")

endmodule

// ----- hw/rtl/gpe_echo.sv -----
// Ping echo unit: millisecond counter, trigger time, arm flag, target
// distance and echo window. Depends on gpe_pkg and the assertion header.
`include "gpio_ports_with_ping_echo_unit_assert.svh"

module gpe_echo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gpe_pkg::echo_ctrl_t       ctrl,
  input  logic [gpe_pkg::DATA_W-1:0] cfg_dist,
  output logic [gpe_pkg::DATA_W-1:0] dist_val,
  output logic                      echo
);
  import gpe_pkg::*;

  logic [TIME_BITS-1:0]               now_ms_r;
  logic [TIME_BITS-1:0]               rise_ms_r;
  logic                               armed_r;
  logic [DATA_W-1:0]                  dist_r;
  logic [PROD_W-1:0]                  prod_r;
  logic [PROD_W-1:0]                  prod_nxt;
  logic [QUOT_IN_W+RECIP_W-1:0]       quot_full;
  logic [WIDTH_W-1:0]                 quot;
  logic [WIDTH_W-1:0]                 width;
  logic [TIME_BITS-1:0]               diff;

  // scale the distance once, on the register write
  assign prod_nxt = PROD_W'(cfg_dist) * PROD_W'(DIST_SCALE) + PROD_W'(DIST_ROUND);

  // counter, trigger time, arm flag and distance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_ms_r  <= '0;
      rise_ms_r <= '0;
      armed_r   <= 1'b0;
      dist_r    <= '0;
      prod_r    <= PROD_W'(DIST_ROUND);
    end else begin
      if (ctrl.tick) begin
        now_ms_r <= now_ms_r + TIME_BITS'(1);
      end
      if (ctrl.arm) begin
        rise_ms_r <= now_ms_r;
        armed_r   <= 1'b1;
      end
      if (ctrl.cfg_we) begin
        dist_r <= cfg_dist;
        prod_r <= prod_nxt;
      end
    end
  end

  // divide by 16000: drop 7 bits, then multiply by the reciprocal of 125
  assign quot_full = (QUOT_IN_W+RECIP_W)'(prod_r[PROD_W-1:DIV_SHIFT])
                   * (QUOT_IN_W+RECIP_W)'(RECIP_125);
  assign quot      = quot_full[RECIP_SHIFT +: WIDTH_W];
  assign width     = (quot == '0) ? WIDTH_W'(1) : quot;

  // echo window: 0 < now - rise <= width
  assign diff = now_ms_r - rise_ms_r;
  assign echo = armed_r && (dist_r != '0) && (diff != '0)
             && (diff <= TIME_BITS'(width));
  assign dist_val = dist_r;

  `GPE_ASSERT_NEXT(a_tick_counts, clk, rst_n, ctrl.tick && !ctrl.arm,
                   now_ms_r == $past(now_ms_r) + TIME_BITS'(1), "tick did not advance time")
  `GPE_ASSERT_NEXT(a_arm_sticks, clk, rst_n, ctrl.arm,
                   armed_r && (rise_ms_r == $past(now_ms_r)), "arm did not store the time")
  `GPE_ASSERT_NOW(a_no_echo_idle, clk, rst_n, !armed_r || (dist_r == '0),
                  !echo, "echo high while disarmed or disabled")

endmodule
